// ===== sv/sumo_mode_fsm_with_timed_motor_queue_macros.svh =====
// ----------------------------------------------------------------------------
// Sumo mode controller assertion macros
// Clocked, reset-qualified property checks used by the control RTL file.
// ----------------------------------------------------------------------------
`ifndef SUMO_MODE_FSM_WITH_TIMED_MOTOR_QUEUE_MACROS_SVH
`define SUMO_MODE_FSM_WITH_TIMED_MOTOR_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define SMQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset.
`define SMQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/smq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sumo mode controller package
// Sizes, mode codes, timing constants, register map and shared types.
// ----------------------------------------------------------------------------
package smq_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    // longest refill (survive with both edges) pushes four commands
    localparam int MAX_PUSH    = 4;

    localparam logic [1:0] MODE_SURVIVE = 2'd0;
    localparam logic [1:0] MODE_HUNT    = 2'd1;
    localparam logic [1:0] MODE_TARGET  = 2'd2;
    localparam logic [1:0] MODE_ATTACK  = 2'd3;

    localparam logic [8:0] REVERSE_MS = 9'd150;
    localparam logic [8:0] TURN_MS    = 9'd200;
    localparam logic [8:0] HUNT_MS    = 9'd250;
    localparam logic [8:0] ATTACK_MS  = 9'd300;
    localparam logic [8:0] PIVOT_MS   = 9'd400;
    localparam logic [8:0] ZERO_MS    = 9'd0;

    localparam logic signed [15:0] PIVOT_SPEED  = 16'sd16000;
    localparam logic signed [15:0] TARGET_SPEED = 16'sd19000;

    localparam logic [1:0] LED_OFF   = 2'd0;
    localparam logic [1:0] LED_ONE   = 2'd1;
    localparam logic [1:0] LED_TWO   = 2'd2;
    localparam logic [1:0] LED_BOTH  = 2'd3;

    // register map, index = paddr[4:2]
    localparam logic [2:0] REG_LINE_LEVEL          = 3'd0;
    localparam logic [2:0] REG_SIDE_DETECT_LEVEL   = 3'd1;
    localparam logic [2:0] REG_CENTER_DETECT_LEVEL = 3'd2;
    localparam logic [2:0] REG_CENTER_CLOSE_LEVEL  = 3'd3;
    localparam logic [2:0] REG_BACK_SPD            = 3'd4;
    localparam logic [2:0] REG_SPIN_SPD            = 3'd5;
    localparam logic [2:0] REG_CRUISE_SPD          = 3'd6;
    localparam logic [2:0] REG_CHARGE_SPD          = 3'd7;

    localparam logic [11:0] RST_LINE_LEVEL          = 12'd2800;
    localparam logic [11:0] RST_SIDE_DETECT_LEVEL   = 12'd1200;
    localparam logic [11:0] RST_CENTER_DETECT_LEVEL = 12'd1000;
    localparam logic [11:0] RST_CENTER_CLOSE_LEVEL  = 12'd2000;
    localparam logic [14:0] RST_BACK_SPD            = 15'd12000;
    localparam logic [14:0] RST_SPIN_SPD            = 15'd15000;
    localparam logic [14:0] RST_CRUISE_SPD          = 15'd17500;
    localparam logic [14:0] RST_CHARGE_SPD          = 15'd19999;

    typedef struct packed {
        logic [11:0] line_level;
        logic [11:0] side_detect_level;
        logic [11:0] center_detect_level;
        logic [11:0] center_close_level;
        logic [14:0] back_spd;
        logic [14:0] spin_spd;
        logic [14:0] cruise_spd;
        logic [14:0] charge_spd;
    } cfg_t;

    typedef struct packed {
        logic right_edge;
        logic left_edge;
        logic seen_l;
        logic seen_r;
        logic seen_c;
        logic close;
    } sense_t;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic [8:0]         len_ms;
    } cmd_t;

    typedef struct packed {
        logic               speed_update;
        logic signed [15:0] left_drive;
        logic signed [15:0] right_drive;
        logic [1:0]         mode;
        logic               led_one;
        logic               led_two;
        logic               queue_busy;
    } result_t;

endpackage

// ===== sv/smq_sense.sv =====
// ----------------------------------------------------------------------------
// Sensor thresholding
// Turns the five ADC readings into edge and opponent flags.
// ----------------------------------------------------------------------------
module smq_sense
    import smq_pkg::*;
(
    input  logic [11:0] left_range,
    input  logic [11:0] right_range,
    input  logic [11:0] right_line,
    input  logic [11:0] left_line,
    input  logic [11:0] center_range,
    input  cfg_t        cfg,
    output sense_t      flags
);

    always_comb begin
        flags.right_edge = right_line < cfg.line_level;
        flags.left_edge  = left_line < cfg.line_level;
        flags.seen_l     = left_range >= cfg.side_detect_level;
        flags.seen_r     = right_range >= cfg.side_detect_level;
        flags.seen_c     = center_range >= cfg.center_detect_level;
        flags.close      = center_range >= cfg.center_close_level;
    end

endmodule

// ===== sv/smq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Mode machine and timed motor command queue
// Mode transitions, queue refill on mode entry and issue of one due command.
// ----------------------------------------------------------------------------
`include "sumo_mode_fsm_with_timed_motor_queue_macros.svh"

module smq_ctrl
    import smq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  sense_t      flags,
    input  logic [31:0] now_ms,
    input  cfg_t        cfg,
    output result_t     res
);

    logic [1:0]       mode_reg, mode_next;
    logic [1:0]       led_reg, led_next;
    logic             running_reg, running_next;
    logic [CNT_W-1:0] cmd_count_reg, cmd_count_next;
    logic [CNT_W-1:0] cmd_pos_reg, cmd_pos_next;
    logic [31:0]      due_time_reg, due_time_next;
    cmd_t             queue_reg [QUEUE_DEPTH];

    logic             edge_any, seen_any;
    logic             go_survive, go_hunt, go_target, go_attack, entering;
    logic signed [15:0] rev_n, turn_p, turn_n, fwd_p, atk_p;
    cmd_t             turn_cmd, rev_cmd, fwd_cmd;
    cmd_t             new_cmd [MAX_PUSH];
    logic [CNT_W-1:0] new_count;
    logic             cur_running;
    logic [CNT_W-1:0] cur_pos, cur_count;
    logic [31:0]      cur_due;
    cmd_t             head;
    logic             upd;

    assign edge_any = flags.right_edge || flags.left_edge;
    assign seen_any = flags.seen_c || flags.seen_l || flags.seen_r;

    // transition decision, taken on the mode before this pass;
    // the last arm of each chain means the mode holds
    always_comb begin
        go_survive = 1'b0;
        go_hunt    = 1'b0;
        go_target  = 1'b0;
        go_attack  = 1'b0;
        unique case (mode_reg)
            MODE_SURVIVE: begin
                priority if (!running_reg) go_hunt = 1'b1;
                else if (edge_any)         go_survive = 1'b1;
                else                       go_hunt = 1'b0;
            end
            MODE_ATTACK: begin
                priority if (edge_any)   go_survive = 1'b1;
                else if (!seen_any)      go_hunt = 1'b1;
                else if (flags.seen_c)   go_target = 1'b1;
                else                     go_target = 1'b0;
            end
            MODE_TARGET: begin
                priority if (edge_any)   go_survive = 1'b1;
                else if (!seen_any)      go_hunt = 1'b1;
                else if (flags.close)    go_attack = 1'b1;
                else                     go_attack = 1'b0;
            end
            MODE_HUNT: begin
                priority if (edge_any) go_survive = 1'b1;
                else if (seen_any) begin
                    if (flags.close) go_attack = 1'b1;
                    else             go_target = 1'b1;
                end else if (!running_reg) go_hunt = 1'b1;
                else go_hunt = 1'b0;
            end
        endcase
    end

    assign entering = go_survive || go_hunt || go_target || go_attack;

    // speed registers are 15b magnitudes, never negative in 16b signed
    assign rev_n  = -signed'({1'b0, cfg.back_spd});
    assign turn_p = signed'({1'b0, cfg.spin_spd});
    assign turn_n = -turn_p;
    assign fwd_p  = signed'({1'b0, cfg.cruise_spd});
    assign atk_p  = signed'({1'b0, cfg.charge_spd});

    // right edge spins left: left wheel back, right wheel forward
    assign turn_cmd = flags.right_edge ? cmd_t'{turn_n, turn_p, TURN_MS}
                                       : cmd_t'{turn_p, turn_n, TURN_MS};
    assign rev_cmd  = '{rev_n, rev_n, REVERSE_MS};
    assign fwd_cmd  = '{fwd_p, fwd_p, REVERSE_MS};

    // refill list and mode-entry side effects
    always_comb begin
        for (int i = 0; i < MAX_PUSH; i++) begin
            new_cmd[i] = '0;
        end
        new_count = '0;
        mode_next = mode_reg;
        led_next  = led_reg;
        priority if (go_survive) begin
            mode_next = MODE_SURVIVE;
            if (flags.right_edge && flags.left_edge) begin
                led_next   = LED_BOTH;
                new_cmd[0] = turn_cmd;
                new_cmd[1] = rev_cmd;
                new_cmd[2] = turn_cmd;
                new_cmd[3] = fwd_cmd;
                new_count  = CNT_W'(4);
            end else begin
                led_next   = flags.right_edge ? LED_TWO : LED_ONE;
                new_cmd[0] = rev_cmd;
                new_cmd[1] = turn_cmd;
                new_cmd[2] = fwd_cmd;
                new_count  = CNT_W'(3);
            end
        end else if (go_hunt) begin
            mode_next  = MODE_HUNT;
            led_next   = LED_OFF;
            new_cmd[0] = '{fwd_p, fwd_p, HUNT_MS};
            new_count  = CNT_W'(1);
        end else if (go_target) begin
            mode_next = MODE_TARGET;
            led_next  = LED_OFF;
            priority if (flags.seen_l && !flags.seen_c)
                new_cmd[0] = '{PIVOT_SPEED, -PIVOT_SPEED, PIVOT_MS};
            else if (flags.seen_r && !flags.seen_c)
                new_cmd[0] = '{-PIVOT_SPEED, PIVOT_SPEED, PIVOT_MS};
            else
                new_cmd[0] = '{TARGET_SPEED, TARGET_SPEED, ZERO_MS};
            new_count = CNT_W'(1);
        end else if (go_attack) begin
            mode_next  = MODE_ATTACK;
            led_next   = LED_OFF;
            new_cmd[0] = '{atk_p, atk_p, ATTACK_MS};
            new_count  = CNT_W'(1);
        end else begin
            mode_next = mode_reg;
        end
    end

    // a fresh entry restarts the queue at now, so its head is due at once
    assign cur_running = entering ? 1'b1 : running_reg;
    assign cur_pos     = entering ? '0 : cmd_pos_reg;
    assign cur_count   = entering ? new_count : cmd_count_reg;
    assign cur_due     = entering ? now_ms : due_time_reg;
    assign head        = entering ? new_cmd[0] : queue_reg[cmd_pos_reg[QIDX_W-1:0]];

    always_comb begin
        upd            = 1'b0;
        running_next   = cur_running;
        cmd_pos_next   = cur_pos;
        due_time_next  = cur_due;
        cmd_count_next = cur_count;
        if (cur_running && (now_ms >= cur_due)) begin
            if (cur_pos < cur_count) begin
                upd           = 1'b1;
                due_time_next = cur_due + {23'd0, head.len_ms};
                cmd_pos_next  = cur_pos + CNT_W'(1);
            end else begin
                running_next = 1'b0;
            end
        end
    end

    always_comb begin
        res.speed_update = upd;
        res.left_drive   = upd ? head.left : '0;
        res.right_drive  = upd ? head.right : '0;
        res.mode         = mode_next;
        res.led_one      = led_next[0];
        res.led_two      = led_next[1];
        res.queue_busy   = running_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_SURVIVE;
            led_reg       <= LED_OFF;
            running_reg   <= 1'b0;
            cmd_count_reg <= '0;
            cmd_pos_reg   <= '0;
            due_time_reg  <= '0;
        end else if (step) begin
            mode_reg      <= mode_next;
            led_reg       <= led_next;
            running_reg   <= running_next;
            cmd_count_reg <= cmd_count_next;
            cmd_pos_reg   <= cmd_pos_next;
            due_time_reg  <= due_time_next;
        end
    end

    // queue payload, written only on mode entry
    always_ff @(posedge aclk) begin
        if (step && entering) begin
            for (int i = 0; i < MAX_PUSH; i++) begin
                queue_reg[i] <= new_cmd[i];
            end
        end
    end

    `SMQ_ASSERT_NOW(a_count_bound, 1'b1, cmd_count_reg <= CNT_W'(MAX_PUSH), "queue count overrun")
    `SMQ_ASSERT_NOW(a_pos_bound, 1'b1, cmd_pos_reg <= cmd_count_reg, "queue position past count")
    `SMQ_ASSERT_NEXT(a_upd_running, step && upd, running_reg, "update issued but queue idle")
    `SMQ_ASSERT_NEXT(a_idle_hold, !step, $stable(mode_reg) && $stable(due_time_reg), "state moved without item")

endmodule

// ===== sv/sumo_mode_fsm_with_timed_motor_queue.sv =====
// ----------------------------------------------------------------------------
// Sumo mode controller with timed motor command queue
// Top level: input register, APB register file, control pass, result register.
// ----------------------------------------------------------------------------
// One item is one control-loop pass: five ADC readings plus the millisecond
// time. The block accepts one item per clock while s_ready is high and returns
// exactly one result item for each. The accepted item sits in the input
// register; the pass writes its result into the result register, which
// presents it on the m_ side, and it leaves at the first edge with m_ready
// high. The whole pass (thresholds, mode transition, queue refill and the
// issue of one due command) is combinational logic between those two
// registers, fed by the mode and queue state left by the previous item.
// s_ready drops only while both registers are full and m_ready is low. The
// queue holds 8 commands in flip-flops and needs no clearing after reset.
// Thresholds and speeds are written over APB at byte address 4*index and
// should change only while no item is in flight.
module sumo_mode_fsm_with_timed_motor_queue
    import smq_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // input channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [11:0]        s_left_range,
    input  logic [11:0]        s_right_range,
    input  logic [11:0]        s_right_line,
    input  logic [11:0]        s_left_line,
    input  logic [11:0]        s_center_range,
    input  logic [31:0]        s_now_ms,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_speed_update,
    output logic signed [15:0] m_left_drive,
    output logic signed [15:0] m_right_drive,
    output logic [1:0]         m_mode,
    output logic               m_led_one,
    output logic               m_led_two,
    output logic               m_queue_busy,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    cfg_t        cfg_reg;
    logic        in_valid_reg;
    logic [11:0] left_range_reg, right_range_reg, right_line_reg;
    logic [11:0] left_line_reg, center_range_reg;
    logic [31:0] now_ms_reg;
    logic        out_valid_reg;
    result_t     out_reg;

    logic        out_free;
    logic        step;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;
    sense_t      flags;
    result_t     res;

    // ---------------- configuration registers ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.line_level          <= RST_LINE_LEVEL;
            cfg_reg.side_detect_level   <= RST_SIDE_DETECT_LEVEL;
            cfg_reg.center_detect_level <= RST_CENTER_DETECT_LEVEL;
            cfg_reg.center_close_level  <= RST_CENTER_CLOSE_LEVEL;
            cfg_reg.back_spd            <= RST_BACK_SPD;
            cfg_reg.spin_spd            <= RST_SPIN_SPD;
            cfg_reg.cruise_spd          <= RST_CRUISE_SPD;
            cfg_reg.charge_spd          <= RST_CHARGE_SPD;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_LINE_LEVEL:          cfg_reg.line_level          <= pwdata[11:0];
                REG_SIDE_DETECT_LEVEL:   cfg_reg.side_detect_level   <= pwdata[11:0];
                REG_CENTER_DETECT_LEVEL: cfg_reg.center_detect_level <= pwdata[11:0];
                REG_CENTER_CLOSE_LEVEL:  cfg_reg.center_close_level  <= pwdata[11:0];
                REG_BACK_SPD:            cfg_reg.back_spd            <= pwdata[14:0];
                REG_SPIN_SPD:            cfg_reg.spin_spd            <= pwdata[14:0];
                REG_CRUISE_SPD:          cfg_reg.cruise_spd          <= pwdata[14:0];
                REG_CHARGE_SPD:          cfg_reg.charge_spd          <= pwdata[14:0];
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_LINE_LEVEL:          prdata = {20'd0, cfg_reg.line_level};
            REG_SIDE_DETECT_LEVEL:   prdata = {20'd0, cfg_reg.side_detect_level};
            REG_CENTER_DETECT_LEVEL: prdata = {20'd0, cfg_reg.center_detect_level};
            REG_CENTER_CLOSE_LEVEL:  prdata = {20'd0, cfg_reg.center_close_level};
            REG_BACK_SPD:            prdata = {17'd0, cfg_reg.back_spd};
            REG_SPIN_SPD:            prdata = {17'd0, cfg_reg.spin_spd};
            REG_CRUISE_SPD:          prdata = {17'd0, cfg_reg.cruise_spd};
            REG_CHARGE_SPD:          prdata = {17'd0, cfg_reg.charge_spd};
        endcase
    end

    // ---------------- handshake ----------------
    // the pass runs whenever an item sits in the input register and the
    // result register is empty or being drained this cycle
    assign out_free = !out_valid_reg || m_ready;
    assign step     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (step) begin
            in_valid_reg <= 1'b0;
        end
    end

    // input payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            left_range_reg   <= s_left_range;
            right_range_reg  <= s_right_range;
            right_line_reg   <= s_right_line;
            left_line_reg    <= s_left_line;
            center_range_reg <= s_center_range;
            now_ms_reg       <= s_now_ms;
        end
    end

    // ---------------- control pass ----------------
    smq_sense u_sense (
        .left_range   (left_range_reg),
        .right_range  (right_range_reg),
        .right_line   (right_line_reg),
        .left_line    (left_line_reg),
        .center_range (center_range_reg),
        .cfg          (cfg_reg),
        .flags        (flags)
    );

    smq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .flags   (flags),
        .now_ms  (now_ms_reg),
        .cfg     (cfg_reg),
        .res     (res)
    );

    // ---------------- result register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_reg <= res;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_speed_update = out_reg.speed_update;
    assign m_left_drive   = out_reg.left_drive;
    assign m_right_drive  = out_reg.right_drive;
    assign m_mode         = out_reg.mode;
    assign m_led_one      = out_reg.led_one;
    assign m_led_two      = out_reg.led_two;
    assign m_queue_busy   = out_reg.queue_busy;

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// Sumo mode controller testbench
// Sends control passes through the valid/ready input channel and predicts each
// result item with a cycle-free model of the mode machine and motor queue.
// Every result is checked field by field. Thresholds and speeds are written
// over APB and read back between phases. The run goes through six register
// settings and three idle patterns on the two channels.
// ----------------------------------------------------------------------------
module tb;
    import smq_pkg::*;

    // one control pass as it crosses the input channel
    typedef struct packed {
        logic [11:0] left_range;
        logic [11:0] right_range;
        logic [11:0] right_line;
        logic [11:0] left_line;
        logic [11:0] center_range;
        logic [31:0] now_ms;
    } pass_t;

    // quiet cycles allowed before the run is declared hung; the longest
    // legal quiet stretch is the forced receiver hold plus a phase change
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 150;
    localparam int PRINT_LIMIT  = 40;

    // ------------------------------------------------------------------
    // DUT signals, all inputs known from time zero
    // ------------------------------------------------------------------
    logic               aclk           = 1'b0;
    logic               aresetn        = 1'b0;
    logic               s_valid        = 1'b0;
    logic               s_ready;
    logic [11:0]        s_left_range   = '0;
    logic [11:0]        s_right_range  = '0;
    logic [11:0]        s_right_line   = '0;
    logic [11:0]        s_left_line    = '0;
    logic [11:0]        s_center_range = '0;
    logic [31:0]        s_now_ms       = '0;
    logic               m_valid;
    logic               m_ready        = 1'b0;
    logic               m_speed_update;
    logic signed [15:0] m_left_drive;
    logic signed [15:0] m_right_drive;
    logic [1:0]         m_mode;
    logic               m_led_one;
    logic               m_led_two;
    logic               m_queue_busy;
    logic               psel           = 1'b0;
    logic               penable        = 1'b0;
    logic               pwrite         = 1'b0;
    logic [4:0]         paddr          = '0;
    logic [31:0]        pwdata         = '0;
    logic [31:0]        prdata;
    logic               pready;

    sumo_mode_fsm_with_timed_motor_queue dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_left_range   (s_left_range),
        .s_right_range  (s_right_range),
        .s_right_line   (s_right_line),
        .s_left_line    (s_left_line),
        .s_center_range (s_center_range),
        .s_now_ms       (s_now_ms),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_speed_update (m_speed_update),
        .m_left_drive   (m_left_drive),
        .m_right_drive  (m_right_drive),
        .m_mode         (m_mode),
        .m_led_one      (m_led_one),
        .m_led_two      (m_led_two),
        .m_queue_busy   (m_queue_busy),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Controller prediction: own copy of config, mode and motor queue
    // ------------------------------------------------------------------
    cfg_t               cfg;
    logic [1:0]         ctl_mode   = MODE_SURVIVE;
    logic               q_running  = 1'b0;
    int                 q_count    = 0;
    int                 q_pos      = 0;
    logic [31:0]        q_due      = '0;
    logic signed [15:0] q_left  [QUEUE_DEPTH];
    logic signed [15:0] q_right [QUEUE_DEPTH];
    logic [8:0]         q_len   [QUEUE_DEPTH];
    logic [1:0]         led_bits   = LED_OFF;

    // every mode entry flushes the queue and restarts it at the pass time
    function automatic void restart_queue(logic [31:0] now);
        q_running = 1'b1;
        q_count   = 0;
        q_pos     = 0;
        q_due     = now;
    endfunction

    // commands past the queue depth are dropped
    function automatic void push_cmd(int l, int r, logic [8:0] ms);
        if (q_count < QUEUE_DEPTH) begin
            q_left[q_count]  = 16'(l);
            q_right[q_count] = 16'(r);
            q_len[q_count]   = ms;
            q_count++;
        end
    endfunction

    function automatic void enter_survive(bit re, bit le, logic [31:0] now);
        int t;
        int dir;
        t        = int'(cfg.spin_spd);
        dir      = re ? -1 : 1;           // right edge: spin to the left
        ctl_mode = MODE_SURVIVE;
        led_bits = re ? LED_TWO : LED_ONE;
        restart_queue(now);
        if (re && le) begin
            // both edges: an extra spin ahead of the usual back-off
            led_bits = LED_BOTH;
            push_cmd(dir * t, -dir * t, TURN_MS);
        end
        push_cmd(-int'(cfg.back_spd), -int'(cfg.back_spd), REVERSE_MS);
        push_cmd(dir * t, -dir * t, TURN_MS);
        push_cmd(int'(cfg.cruise_spd), int'(cfg.cruise_spd), REVERSE_MS);
    endfunction

    function automatic void enter_hunt(logic [31:0] now);
        ctl_mode = MODE_HUNT;
        led_bits = LED_OFF;
        restart_queue(now);
        push_cmd(int'(cfg.cruise_spd), int'(cfg.cruise_spd), HUNT_MS);
    endfunction

    function automatic void enter_target(bit sl, bit sr, bit sc, logic [31:0] now);
        ctl_mode = MODE_TARGET;
        led_bits = LED_OFF;
        restart_queue(now);
        if (sl && !sc)
            push_cmd(int'(PIVOT_SPEED), -int'(PIVOT_SPEED), PIVOT_MS);
        else if (sr && !sc)
            push_cmd(-int'(PIVOT_SPEED), int'(PIVOT_SPEED), PIVOT_MS);
        else
            push_cmd(int'(TARGET_SPEED), int'(TARGET_SPEED), ZERO_MS);
    endfunction

    function automatic void enter_attack(logic [31:0] now);
        ctl_mode = MODE_ATTACK;
        led_bits = LED_OFF;
        restart_queue(now);
        push_cmd(int'(cfg.charge_spd), int'(cfg.charge_spd), ATTACK_MS);
    endfunction

    // one full control pass: thresholds, transition, then issue of one due command
    function automatic result_t control_pass(pass_t p);
        bit      re, le, on_edge, sc, sl, sr, any_seen, near_c;
        result_t r;
        re       = p.right_line < cfg.line_level;
        le       = p.left_line < cfg.line_level;
        on_edge  = re || le;
        sc       = p.center_range >= cfg.center_detect_level;
        sl       = p.left_range >= cfg.side_detect_level;
        sr       = p.right_range >= cfg.side_detect_level;
        any_seen = sc || sl || sr;
        near_c   = p.center_range >= cfg.center_close_level;

        case (ctl_mode)
            MODE_SURVIVE: begin
                // survive finishes its sequence before leaving
                if (!q_running) enter_hunt(p.now_ms);
                else if (on_edge) enter_survive(re, le, p.now_ms);
            end
            MODE_ATTACK: begin
                if (on_edge) enter_survive(re, le, p.now_ms);
                else if (!any_seen) enter_hunt(p.now_ms);
                else if (sc) enter_target(sl, sr, sc, p.now_ms);
            end
            MODE_TARGET: begin
                if (on_edge) enter_survive(re, le, p.now_ms);
                else if (!any_seen) enter_hunt(p.now_ms);
                else if (near_c) enter_attack(p.now_ms);
            end
            default: begin
                if (on_edge) enter_survive(re, le, p.now_ms);
                else if (any_seen) begin
                    if (near_c) enter_attack(p.now_ms);
                    else enter_target(sl, sr, sc, p.now_ms);
                end else if (!q_running) enter_hunt(p.now_ms);
            end
        endcase

        r = '0;
        // plain unsigned compare, due time wraps mod 2^32
        if (q_running && p.now_ms >= q_due) begin
            if (q_pos < q_count) begin
                r.speed_update = 1'b1;
                r.left_drive   = q_left[q_pos];
                r.right_drive  = q_right[q_pos];
                q_due          = q_due + 32'(q_len[q_pos]);
                q_pos++;
            end else begin
                q_running = 1'b0;
            end
        end
        r.mode       = ctl_mode;
        r.led_one    = led_bits[0];
        r.led_two    = led_bits[1];
        r.queue_busy = q_running;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus store and channel state
    // ------------------------------------------------------------------
    pass_t       pending_passes[$];
    result_t     expected_results[$];
    cfg_t        settings[6];
    logic [31:0] clock_ms          = '0;
    int          sender_idle_pct   = 0;
    int          receiver_idle_pct = 0;
    int          hold_requests     = 0;
    int          holds_served      = 0;
    int          hold_left         = 0;
    bit          in_taken          = 1'b0;
    int          quiet_cycles      = 0;
    int          mismatches        = 0;
    int          passes_checked    = 0;
    int          updates_seen      = 0;
    int          mode_hits[4]      = '{0, 0, 0, 0};

    // reading on the chosen side of a threshold, often right at the boundary
    function automatic logic [11:0] level_pick(logic [11:0] thr, bit hit);
        if (hit) begin
            if ($urandom_range(0, 3) == 0) return thr;
            return 12'($urandom_range(thr, 4095));
        end
        if (thr == 0) return 12'($urandom_range(0, 4095));
        if ($urandom_range(0, 3) == 0) return 12'(thr - 1);
        return 12'($urandom_range(0, thr - 1));
    endfunction

    // mostly plausible sensor frames on a rising clock; a tenth is pure noise
    function automatic pass_t random_pass();
        pass_t p;
        bit    edge_r, edge_l;
        int    band;
        if ($urandom_range(0, 99) < 10) begin
            p = '{12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                  12'($urandom), $urandom};
            return p;
        end
        edge_r        = $urandom_range(0, 99) < 7;
        edge_l        = $urandom_range(0, 99) < 7;
        p.right_line  = level_pick(cfg.line_level, !edge_r);
        p.left_line   = level_pick(cfg.line_level, !edge_l);
        p.left_range  = level_pick(cfg.side_detect_level, $urandom_range(0, 99) < 35);
        p.right_range = level_pick(cfg.side_detect_level, $urandom_range(0, 99) < 35);
        band          = $urandom_range(0, 2);
        if (band == 0)
            p.center_range = level_pick(cfg.center_detect_level, 1'b0);
        else if (band == 1 && cfg.center_detect_level < cfg.center_close_level)
            p.center_range = 12'($urandom_range(cfg.center_detect_level,
                                                cfg.center_close_level - 1));
        else
            p.center_range = level_pick(band == 2 ? cfg.center_close_level
                                                  : cfg.center_detect_level, 1'b1);
        clock_ms = clock_ms + $urandom_range(0, 120);
        p.now_ms = clock_ms;
        return p;
    endfunction

    function automatic void queue_pass(int lr, int rr, int rl, int ll, int cr,
                                       logic [31:0] now);
        pending_passes.push_back('{12'(lr), 12'(rr), 12'(rl), 12'(ll), 12'(cr), now});
    endfunction

    function automatic void check_field(string fname, logic signed [31:0] want_v,
                                        logic signed [31:0] got_v);
        if (got_v !== want_v) begin
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
                $display("%0t: %s mismatch, expected %0d, got %0d",
                         $time, fname, want_v, got_v);
        end
    endfunction

    // ------------------------------------------------------------------
    // APB: write one register, read it back, mirror it in the predictor
    // ------------------------------------------------------------------
    task automatic set_register(logic [2:0] idx, logic [31:0] val);
        logic [31:0] rd;
        logic [31:0] want;
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);                  // register takes the value here
        case (idx)
            REG_LINE_LEVEL:          cfg.line_level          = val[11:0];
            REG_SIDE_DETECT_LEVEL:   cfg.side_detect_level   = val[11:0];
            REG_CENTER_DETECT_LEVEL: cfg.center_detect_level = val[11:0];
            REG_CENTER_CLOSE_LEVEL:  cfg.center_close_level  = val[11:0];
            REG_BACK_SPD:            cfg.back_spd            = val[14:0];
            REG_SPIN_SPD:            cfg.spin_spd            = val[14:0];
            REG_CRUISE_SPD:          cfg.cruise_spd          = val[14:0];
            default:                 cfg.charge_spd          = val[14:0];
        endcase
        want = (idx < REG_BACK_SPD) ? {20'b0, val[11:0]} : {17'b0, val[14:0]};
        @(negedge aclk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        rd = prdata;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        check_field("register readback", want, rd);
    endtask

    task automatic load_setting(cfg_t s);
        set_register(REG_LINE_LEVEL,          32'(s.line_level));
        set_register(REG_SIDE_DETECT_LEVEL,   32'(s.side_detect_level));
        set_register(REG_CENTER_DETECT_LEVEL, 32'(s.center_detect_level));
        set_register(REG_CENTER_CLOSE_LEVEL,  32'(s.center_close_level));
        set_register(REG_BACK_SPD,            32'(s.back_spd));
        set_register(REG_SPIN_SPD,            32'(s.spin_spd));
        set_register(REG_CRUISE_SPD,          32'(s.cruise_spd));
        set_register(REG_CHARGE_SPD,          32'(s.charge_spd));
    endtask

    // ------------------------------------------------------------------
    // Sender: next item goes out on the falling edge once the last was taken
    // ------------------------------------------------------------------
    always @(negedge aclk) begin : sender
        pass_t nxt;
        if (aresetn && (!s_valid || in_taken)) begin
            if (pending_passes.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                nxt            = pending_passes.pop_front();
                s_valid        <= 1'b1;
                s_left_range   <= nxt.left_range;
                s_right_range  <= nxt.right_range;
                s_right_line   <= nxt.right_line;
                s_left_line    <= nxt.left_line;
                s_center_range <= nxt.center_range;
                s_now_ms       <= nxt.now_ms;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, plus a long hold on request so the
    // block fills both registers and drops s_ready
    // ------------------------------------------------------------------
    always @(negedge aclk) begin : receiver
        if (aresetn) begin
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: handshakes sampled on the rising edge; results are checked
    // before the newly accepted pass is predicted
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        result_t got;
        result_t want;
        in_taken = aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = '{m_speed_update, m_left_drive, m_right_drive, m_mode,
                        m_led_one, m_led_two, m_queue_busy};
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= PRINT_LIMIT)
                        $display("%0t: result item with none expected, got %p", $time, got);
                end else begin
                    want = expected_results.pop_front();
                    check_field("speed_update", want.speed_update, got.speed_update);
                    check_field("left_drive",   want.left_drive,   got.left_drive);
                    check_field("right_drive",  want.right_drive,  got.right_drive);
                    check_field("mode",         want.mode,         got.mode);
                    check_field("led_one",      want.led_one,      got.led_one);
                    check_field("led_two",      want.led_two,      got.led_two);
                    check_field("queue_busy",   want.queue_busy,   got.queue_busy);
                    passes_checked++;
                    if (want.speed_update) updates_seen++;
                    mode_hits[want.mode]++;
                end
            end
            if (in_taken)
                expected_results.push_back(control_pass('{s_left_range, s_right_range,
                    s_right_line, s_left_line, s_center_range, s_now_ms}));

            // watchdog: any handshake resets the quiet count
            if (in_taken || (m_valid && m_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: reset, then six phases of register setting plus items
    // ------------------------------------------------------------------
    initial begin : main
        int ph;
        int n;
        cfg = '{RST_LINE_LEVEL, RST_SIDE_DETECT_LEVEL, RST_CENTER_DETECT_LEVEL,
                RST_CENTER_CLOSE_LEVEL, RST_BACK_SPD, RST_SPIN_SPD,
                RST_CRUISE_SPD, RST_CHARGE_SPD};
        settings[0] = cfg;
        // low extremes: no edge ever, every side reading seen, zero speeds
        settings[1] = '0;
        // high extremes: edges nearly always, full 15-bit speeds
        settings[2] = '{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF,
                        15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF};
        settings[3] = '{12'($urandom_range(1500, 3800)), 12'($urandom_range(600, 2500)),
                        12'($urandom_range(500, 1800)), 12'($urandom_range(1500, 3500)),
                        15'($urandom_range(0, 20000)), 15'($urandom_range(0, 20000)),
                        15'($urandom_range(0, 20000)), 15'($urandom_range(0, 20000))};
        // close level below detect level, top of the speed range
        settings[4] = '{12'd3000, 12'd2500, 12'd3000, 12'd600,
                        15'd20000, 15'd20000, 15'd20000, 15'd20000};
        settings[5] = '{12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                        15'($urandom_range(0, 20000)), 15'($urandom_range(0, 20000)),
                        15'($urandom_range(0, 20000)), 15'($urandom_range(0, 20000))};

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (ph = 0; ph < 6; ph++) begin
            // wait here until every result of the last phase is back and the
            // sender is idle, then touch the registers
            while (pending_passes.size() != 0 || s_valid || expected_results.size() != 0)
                @(posedge aclk);
            repeat (4) @(posedge aclk);
            load_setting(settings[ph]);

            if (ph < 2) begin
                sender_idle_pct   = 28;
                receiver_idle_pct = 78;
            end else if (ph < 4) begin
                sender_idle_pct   = 78;
                receiver_idle_pct = 28;
            end else begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end

            if (ph == 0) begin
                // walk the mode machine through a directed sequence of transitions at reset levels
                queue_pass(0, 0, 4095, 4095, 0, 0);        // first pass: into hunt
                queue_pass(0, 0, 4095, 4095, 0, 100);      // command not yet due
                queue_pass(0, 0, 4095, 4095, 0, 250);      // queue runs dry
                queue_pass(0, 0, 4095, 4095, 0, 260);      // idle hunt refills
                queue_pass(1200, 0, 4095, 4095, 0, 270);   // left only: pivot
                queue_pass(0, 1200, 4095, 4095, 999, 280); // target holds
                queue_pass(0, 0, 4095, 4095, 2000, 290);   // close: attack
                queue_pass(4095, 4095, 4095, 4095, 1000, 300); // center seen: target
                queue_pass(0, 0, 4095, 4095, 1999, 300);   // zero-length command ends
                queue_pass(0, 0, 4095, 4095, 4095, 310);   // close again: attack
                queue_pass(1200, 0, 4095, 4095, 0, 320);   // side only keeps attack
                queue_pass(0, 0, 4095, 4095, 0, 330);      // lost: hunt
                queue_pass(0, 0, 2799, 4095, 0, 340);      // right edge
                queue_pass(0, 0, 0, 0, 0, 350);            // both edges, four commands
                queue_pass(0, 0, 4095, 4095, 0, 500);
                queue_pass(0, 0, 4095, 4095, 0, 550);
                queue_pass(0, 0, 4095, 4095, 0, 700);
                queue_pass(0, 0, 4095, 4095, 0, 900);
                queue_pass(0, 0, 4095, 4095, 0, 1050);     // survive sequence done
                queue_pass(0, 0, 4095, 4095, 0, 1060);     // back to hunt
                queue_pass(0, 0, 4095, 2799, 0, 1070);     // left edge
                queue_pass(0, 0, 4095, 4095, 0, 32'hFFFF_FFFF); // time at its top
                queue_pass(0, 0, 4095, 4095, 0, 0);        // time going backwards
                queue_pass(4095, 4095, 4095, 4095, 4095, 0);
                clock_ms = 32'd2000;
            end
            if (ph == 3) clock_ms = 32'hFFFF_FE00;  // let the due time wrap
            if (ph == 4) hold_requests++;           // long receiver stall

            n = (ph == 1 || ph == 2) ? 150 : 300;
            repeat (n) pending_passes.push_back(random_pass());
        end

        while (pending_passes.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (expected_results.size() != 0) mismatches++;

        $display("Checked %0d passes across 6 register settings, %0d carrying a speed update.",
                 passes_checked, updates_seen);
        $display("Final modes seen: survive %0d, hunt %0d, target %0d, attack %0d.",
                 mode_hits[MODE_SURVIVE], mode_hits[MODE_HUNT],
                 mode_hits[MODE_TARGET], mode_hits[MODE_ATTACK]);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
